>>> rtl/clle_pkg.sv
`timescale 1ns / 1ps

package clle_pkg;

    // store geometry
    localparam int SLOTS     = 1024;
    localparam int LINK_W    = $clog2(SLOTS);
    localparam int POS_W     = 10;
    localparam int VAL_W     = 32;
    localparam int LEN_W     = 10;
    localparam int CMP_W     = ((LINK_W + 1) > POS_W) ? (LINK_W + 1) : POS_W;
    localparam int HEAD_SLOT = SLOTS - 1;
    localparam int FREE_SLOT = 0;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    typedef enum logic [1:0] {
        RA_ZERO,
        RA_HEAD,
        RA_RDATA
    } t_rd_addr_sel;

    typedef enum logic [2:0] {
        WA_CLR,
        WA_ZERO,
        WA_SLOT,
        WA_K,
        WA_J
    } t_wr_addr_sel;

    typedef enum logic [1:0] {
        WD_INIT,
        WD_RDATA,
        WD_SLOT,
        WD_J
    } t_wr_data_sel;

    typedef struct packed {
        logic         in_ready;
        logic         rd_en;
        t_rd_addr_sel rd_addr_sel;
        logic         wr_en;
        t_wr_addr_sel wr_addr_sel;
        t_wr_data_sel wr_data_sel;
        logic         val_wr;
        logic         clr_inc;
        logic         init_walk;
        logic         step_walk;
        logic         load_slot;
        logic         load_j;
        logic         ok_set;
        logic         count_inc;
        logic         count_dec;
        logic         out_load;
    } t_cmd;

    typedef struct packed {
        logic range_ok;
        logic is_delete;
        logic rdata_zero;
        logic pos_one;
        logic hop_one;
        logic clr_last;
        logic out_free;
    } t_status;

endpackage

>>> rtl/cursor_linked_list_engine.sv
`timescale 1ns / 1ps

// Cursor linked list engine: one link array holds a free chain (headed by
// slot 0) and a data chain (headed by the last slot). Capacity SLOTS-2.
// Input channel i_in_valid/o_in_ready carries one request per transaction:
// i_req_type (0 insert, 1 delete), 1-based i_position, i_value for inserts.
// Output channel o_out_valid/i_out_ready returns one transaction per request:
// o_ok and o_list_length (element count after the request).
// An accepted request is range-checked, then an insert pops the free chain and both
// kinds walk the data chain; a range reject or a full store goes straight to the result.
// Requests are taken one at a time; the chain walk does one registered link memory
// read per hop, and o_in_ready stays low until the result is loaded.
// Reset (synchronous, i_rst_n low): count and output clear, then a clearing
// pass writes the reset links, one slot per cycle through all SLOTS slots, with
// o_in_ready low.
// Stall: the result sits in an output register; the engine takes the next
// request while it waits, and holds a new result until the old one is taken.

module cursor_linked_list_engine
    import clle_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_req_type,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_ok,
    output logic [LEN_W-1:0]        o_list_length
);

    t_cmd    cmd;
    t_status status;

    // sequencer: walk, pop/push of the free chain, result hand-off
    clle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // link memory, request registers, count and output register
    clle_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_in_valid    (i_in_valid),
        .i_req_type    (i_req_type),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ok          (o_ok),
        .o_list_length (o_list_length)
    );

    assign o_in_ready = cmd.in_ready;

endmodule

>>> rtl/clle_dp.sv
`timescale 1ns / 1ps

module clle_dp
    import clle_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic                    i_in_valid,
    input  logic                    i_req_type,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_ok,
    output logic [LEN_W-1:0]        o_list_length
);

    logic [LINK_W-1:0] r_link_mem [SLOTS];
    logic [VAL_W-1:0]  r_val_mem  [SLOTS];

    logic              r_req;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_value;
    logic [LINK_W-1:0] r_count, n_count;
    logic [LINK_W-1:0] r_clr;
    logic [POS_W-1:0]  r_hop;
    logic [LINK_W-1:0] r_k;
    logic [LINK_W-1:0] r_slot;
    logic [LINK_W-1:0] r_j;
    logic [LINK_W-1:0] r_rdata;
    logic              r_ok;
    logic              r_out_valid;
    logic              r_out_ok;
    logic [LEN_W-1:0]  r_out_len;

    logic [LINK_W-1:0] rd_addr;
    logic [LINK_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic [LINK_W-1:0] init_link;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              accept;

    assign accept  = i_in_valid && i_cmd.in_ready;
    assign pos_ext = CMP_W'(r_pos);
    assign cnt_ext = CMP_W'(r_count);

    // reset image: slot i links i+1, the last two end their chains
    assign init_link = (r_clr < LINK_W'(SLOTS - 2)) ? (r_clr + LINK_W'(1)) : '0;

    always_comb begin
        unique case (i_cmd.rd_addr_sel)
            RA_ZERO:  rd_addr = LINK_W'(FREE_SLOT);
            RA_HEAD:  rd_addr = LINK_W'(HEAD_SLOT);
            RA_RDATA: rd_addr = r_rdata;
            default:  rd_addr = r_rdata;
        endcase
        unique case (i_cmd.wr_addr_sel)
            WA_CLR:  wr_addr = r_clr;
            WA_ZERO: wr_addr = LINK_W'(FREE_SLOT);
            WA_SLOT: wr_addr = r_slot;
            WA_K:    wr_addr = r_k;
            WA_J:    wr_addr = r_j;
            default: wr_addr = r_k;
        endcase
        unique case (i_cmd.wr_data_sel)
            WD_INIT:  wr_data = init_link;
            WD_RDATA: wr_data = r_rdata;
            WD_SLOT:  wr_data = r_slot;
            WD_J:     wr_data = r_j;
            default:  wr_data = r_rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_link_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_link_mem[rd_addr];
        end
        if (i_cmd.val_wr) begin
            r_val_mem[r_slot] <= r_value;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.count_inc) begin
            n_count = r_count + LINK_W'(1);
        end else if (i_cmd.count_dec) begin
            n_count = r_count - LINK_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.clr_inc) begin
                r_clr <= r_clr + LINK_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_req_type;
            r_pos   <= i_position;
            r_value <= i_value;
            r_ok    <= 1'b0;
        end else if (i_cmd.ok_set) begin
            r_ok <= 1'b1;
        end
        if (i_cmd.init_walk) begin
            r_k   <= LINK_W'(HEAD_SLOT);
            r_hop <= r_pos - POS_W'(1);
        end else if (i_cmd.step_walk) begin
            r_k   <= r_rdata;
            r_hop <= r_hop - POS_W'(1);
        end
        if (i_cmd.load_slot) begin
            r_slot <= r_rdata;
        end
        if (i_cmd.load_j) begin
            r_j <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_ok  <= r_ok;
            r_out_len <= cnt_ext[LEN_W-1:0];
        end
    end

    always_comb begin
        o_status.is_delete  = (r_req == REQ_DELETE);
        o_status.range_ok   = (r_pos != '0) &&
                              ((r_req == REQ_DELETE) ? (pos_ext <= cnt_ext)
                                                     : (pos_ext <= cnt_ext + CMP_W'(1)));
        o_status.rdata_zero = (r_rdata == '0);
        o_status.pos_one    = (r_pos == POS_W'(1));
        o_status.hop_one    = (r_hop == POS_W'(1));
        o_status.clr_last   = (r_clr == LINK_W'(SLOTS - 1));
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_out_ok;
    assign o_list_length = r_out_len;

endmodule

>>> rtl/clle_ctrl.sv
`timescale 1ns / 1ps

module clle_ctrl
    import clle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_CHECK  = 12'b0000_0000_0100,
        S_IFREE  = 12'b0000_0000_1000,
        S_IPOP   = 12'b0000_0001_0000,
        S_WALK   = 12'b0000_0010_0000,
        S_KRD    = 12'b0000_0100_0000,
        S_ILINK  = 12'b0000_1000_0000,
        S_DJN    = 12'b0001_0000_0000,
        S_DF     = 12'b0010_0000_0000,
        S_DHEAD  = 12'b0100_0000_0000,
        S_FINISH = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_addr_sel = RA_ZERO;
        o_cmd.wr_addr_sel = WA_CLR;
        o_cmd.wr_data_sel = WD_INIT;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.clr_inc = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.range_ok) begin
                    n_state = S_FINISH;
                end else if (i_status.is_delete) begin
                    o_cmd.rd_en       = 1'b1;
                    o_cmd.rd_addr_sel = RA_HEAD;
                    o_cmd.init_walk   = 1'b1;
                    n_state = i_status.pos_one ? S_KRD : S_WALK;
                end else begin
                    o_cmd.rd_en       = 1'b1;
                    o_cmd.rd_addr_sel = RA_ZERO;
                    n_state = S_IFREE;
                end
            end
            S_IFREE: begin
                if (i_status.rdata_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.load_slot   = 1'b1;
                    o_cmd.rd_en       = 1'b1;
                    o_cmd.rd_addr_sel = RA_RDATA;
                    n_state = S_IPOP;
                end
            end
            S_IPOP: begin
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_addr_sel = WA_ZERO;
                o_cmd.wr_data_sel = WD_RDATA;
                o_cmd.rd_en       = 1'b1;
                o_cmd.rd_addr_sel = RA_HEAD;
                o_cmd.init_walk   = 1'b1;
                n_state = i_status.pos_one ? S_KRD : S_WALK;
            end
            S_WALK: begin
                o_cmd.step_walk   = 1'b1;
                o_cmd.rd_en       = 1'b1;
                o_cmd.rd_addr_sel = RA_RDATA;
                if (i_status.hop_one) begin
                    n_state = S_KRD;
                end
            end
            S_KRD: begin
                if (!i_status.is_delete) begin
                    o_cmd.wr_en       = 1'b1;
                    o_cmd.wr_addr_sel = WA_SLOT;
                    o_cmd.wr_data_sel = WD_RDATA;
                    n_state = S_ILINK;
                end else begin
                    o_cmd.load_j = 1'b1;
                    if (i_status.rdata_zero) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.rd_en       = 1'b1;
                        o_cmd.rd_addr_sel = RA_RDATA;
                        n_state = S_DJN;
                    end
                end
            end
            S_ILINK: begin
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_addr_sel = WA_K;
                o_cmd.wr_data_sel = WD_SLOT;
                o_cmd.val_wr      = 1'b1;
                o_cmd.count_inc   = 1'b1;
                o_cmd.ok_set      = 1'b1;
                n_state = S_FINISH;
            end
            S_DJN: begin
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_addr_sel = WA_K;
                o_cmd.wr_data_sel = WD_RDATA;
                o_cmd.rd_en       = 1'b1;
                o_cmd.rd_addr_sel = RA_ZERO;
                n_state = S_DF;
            end
            S_DF: begin
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_addr_sel = WA_J;
                o_cmd.wr_data_sel = WD_RDATA;
                n_state = S_DHEAD;
            end
            S_DHEAD: begin
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_addr_sel = WA_ZERO;
                o_cmd.wr_data_sel = WD_J;
                o_cmd.count_dec   = 1'b1;
                o_cmd.ok_set      = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/clle_checker.sv
`timescale 1ns / 1ps

module clle_checker
    import clle_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic             o_ok,
    input logic [LEN_W-1:0] o_list_length
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_ok) && $stable(o_list_length)))
        else $error("result changed while stalled");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in flight");

    // reset starts the clearing pass with nothing pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_in_ready && !o_out_valid))
        else $error("ready or result right after reset");

endmodule

bind cursor_linked_list_engine clle_checker u_clle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_ok          (o_ok),
    .o_list_length (o_list_length)
);
